// ===== rtl/core/indent_style_detector_assert.svh =====
// Assertion macros shared by the indent style detector modules.
`ifndef INDENT_STYLE_DETECTOR_ASSERT_SVH
`define INDENT_STYLE_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ISD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ISD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ISD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ISD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/isd_pkg.sv =====
// Package with shared constants and types of the indent style detector.
package isd_pkg;
    localparam int HistDepth = 54;
    localparam int HistIdxW = $clog2(HistDepth);
    localparam int CntW = 16;
    localparam logic [CntW-1:0] CntMax = '1;
    localparam logic [7:0] TabChar = 8'd9;
    localparam logic [7:0] SpaceChar = 8'd32;
    localparam logic [7:0] StarChar = 8'd42;
    localparam logic [15:0] LimitReset = 16'd5000;
    localparam logic [0:0] RegSkipStar = 1'b0;
    localparam logic [0:0] RegLineLimit = 1'b1;
    localparam logic [1:0] TypeNone = 2'd0;
    localparam logic [1:0] TypeSpaces = 2'd1;
    localparam logic [1:0] TypeTabs = 2'd2;
    localparam int QDepth = 2;

    // Classified line handed from front to back.
    typedef struct packed {
        logic                tab;
        logic                space;
        logic [HistIdxW-1:0] width;
        logic                last;
    } isd_cmd_t;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == CntMax) ? v : v + 1'b1;
    endfunction
endpackage

// ===== rtl/core/isd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module isd_ram #(
    parameter int Width = 16,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/isd_front.sv =====
// Front end: line limit, skip rules and classification of each line.
module isd_front
    import isd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [11:0]       s_indent_width,
    input  logic [7:0]        s_head_char,
    input  logic [7:0]        s_after_indent_char,
    input  logic              s_last_line,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              q_push,
    output isd_cmd_t          q_cmd,
    input  logic              q_full
);
    `include "indent_style_detector_assert.svh"

    logic        skip_star_reg;
    logic [15:0] line_limit_reg;
    logic [15:0] lines_seen_reg, lines_seen_next;
    logic        take, tally, skip;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign take      = s_valid && s_ready;
    assign tally     = lines_seen_reg < line_limit_reg;
    assign skip      = (s_indent_width >= 12'(HistDepth))
                       || (skip_star_reg && s_after_indent_char == StarChar);

    always_comb begin
        q_cmd.tab   = tally && !skip && s_head_char == TabChar;
        q_cmd.space = tally && !skip && s_head_char == SpaceChar;
        q_cmd.width = s_indent_width[HistIdxW-1:0];
        q_cmd.last  = s_last_line;
        lines_seen_next = lines_seen_reg;
        if (take) begin
            if (s_last_line) begin
                lines_seen_next = '0;
            end else if (tally) begin
                lines_seen_next = sat_inc(lines_seen_reg);
            end
        end
    end
    assign q_push = take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_star_reg  <= 1'b0;
            line_limit_reg <= LimitReset;
            lines_seen_reg <= '0;
        end else begin
            lines_seen_reg <= lines_seen_next;
            if (cfg_valid) begin
                if (cfg_index == RegSkipStar) begin
                    skip_star_reg <= cfg_data[0];
                end else begin
                    line_limit_reg <= cfg_data;
                end
            end
        end
    end

    `ISD_ASSERT_IMPL(a_no_double_class, aclk, aresetn, q_push, !(q_cmd.tab && q_cmd.space))
    `ISD_ASSERT_IMPL(a_no_push_full, aclk, aresetn, q_full, !q_push)
    `ISD_ASSERT_NEXT(a_last_clears, aclk, aresetn, q_push && q_cmd.last, lines_seen_reg == '0)
endmodule

// ===== rtl/core/isd_queue.sv =====
// Short queue of classified lines between front and back.
module isd_queue
    import isd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  isd_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output isd_cmd_t head
);
    `include "indent_style_detector_assert.svh"

    localparam int PtrW = $clog2(QDepth);
    isd_cmd_t         slot_reg [QDepth];
    logic [PtrW-1:0]  wr_reg, rd_reg;
    logic [PtrW:0]    cnt_reg;

    assign full      = cnt_reg == (PtrW+1)'(QDepth);
    assign not_empty = cnt_reg != '0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PtrW'(QDepth-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PtrW'(QDepth-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    `ISD_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, not_empty)
    `ISD_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= (PtrW+1)'(QDepth))
    `ISD_ASSERT_IMPL(a_no_push_full_q, aclk, aresetn, full, !push)
endmodule

// ===== rtl/core/isd_back.sv =====
// Back end: tallies, histogram RAM, end-of-document decision and output.
module isd_back
    import isd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  isd_cmd_t    q_cmd,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_indent_type,
    output logic [5:0]  m_indent_size
);
    `include "indent_style_detector_assert.svh"

    localparam logic [2:0] StClear = 3'd0;
    localparam logic [2:0] StRun   = 3'd1;
    localparam logic [2:0] StRmw   = 3'd2;
    localparam logic [2:0] StSum   = 3'd3;
    localparam logic [2:0] StPick  = 3'd4;
    localparam logic [2:0] StOut   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CntW-1:0]     tab_reg, space_reg;
    logic [HistIdxW-1:0] addr_reg;    // clear / RMW address
    logic [HistIdxW-1:0] k_reg;       // current divisor
    logic [HistIdxW-1:0] i_reg;       // multiple being read
    logic                rd_pend_reg; // a RAM read is in flight
    logic [21:0]         wsum_reg;
    logic [21:0]         best_reg;
    logic [HistIdxW-1:0] win_reg;
    logic [1:0]          type_reg;
    logic                ram_we;
    logic [HistIdxW-1:0] ram_waddr, ram_raddr;
    logic [CntW-1:0]     ram_wdata, ram_rdata;
    logic [CntW+1:0]     tab4, space4;
    logic [22:0]         best32;
    logic [HistIdxW:0]   i_nx;

    isd_ram #(.Width(CntW), .Depth(HistDepth)) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tab4   = {tab_reg, 2'b00};
    assign space4 = {space_reg, 2'b00};
    assign best32 = ({1'b0, best_reg} + {2'b00, best_reg[21:1]});
    assign i_nx   = {1'b0, i_reg} + {1'b0, k_reg};
    assign q_pop  = (state_reg == StRun) && q_valid;
    // While a divisor is being summed, the next multiple is requested in the
    // same cycle that the current one is added, so one read lands per cycle.
    assign ram_raddr = (state_reg == StRun) ? q_cmd.width
                     : (state_reg == StSum && rd_pend_reg
                        && i_nx < (HistIdxW+1)'(HistDepth)) ? i_nx[HistIdxW-1:0]
                     : i_reg;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        state_next = state_reg;
        unique case (state_reg)
            StClear: begin
                ram_we = 1'b1;
                if (addr_reg == HistIdxW'(HistDepth-1)) begin
                    state_next = StRun;
                end
            end
            StRun: begin
                if (q_valid) begin
                    if (q_cmd.space) begin
                        state_next = StRmw;
                    end else if (q_cmd.last) begin
                        state_next = StSum;
                    end
                end
            end
            StRmw: begin
                ram_we    = 1'b1;
                ram_wdata = sat_inc(ram_rdata);
                state_next = rd_pend_reg ? StSum : StRun;
            end
            StSum: begin
                if (rd_pend_reg && i_nx >= (HistIdxW+1)'(HistDepth)) begin
                    state_next = StPick;
                end
            end
            StPick: begin
                state_next = (k_reg == HistIdxW'(2)) ? StOut : StSum;
            end
            StOut: begin
                if (m_ready) begin
                    state_next = StClear;
                end
            end
            default: state_next = StClear;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StClear;
            addr_reg    <= '0;
            tab_reg     <= '0;
            space_reg   <= '0;
            rd_pend_reg <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            wsum_reg    <= '0;
            best_reg    <= '0;
            win_reg     <= '0;
            type_reg    <= TypeNone;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                StClear: begin
                    addr_reg  <= addr_reg + 1'b1;
                    tab_reg   <= '0;
                    space_reg <= '0;
                    if (state_next == StRun) begin
                        addr_reg <= '0;
                    end
                end
                StRun: begin
                    rd_pend_reg <= 1'b0;
                    if (q_valid) begin
                        addr_reg <= q_cmd.width;
                        if (q_cmd.tab) begin
                            tab_reg <= sat_inc(tab_reg);
                        end
                        if (q_cmd.space) begin
                            space_reg <= sat_inc(space_reg);
                            rd_pend_reg <= q_cmd.last;
                        end
                        k_reg    <= HistIdxW'(HistDepth-1);
                        i_reg    <= HistIdxW'(HistDepth-1);
                        wsum_reg <= '0;
                        best_reg <= '0;
                        win_reg  <= '0;
                    end
                end
                StRmw: begin
                    rd_pend_reg <= 1'b0;
                    // Tallies include this line now: update the type.
                    if (tab_reg == '0 && space_reg == '0) begin
                        type_reg <= TypeNone;
                    end else if ({2'b00, space_reg} > tab4) begin
                        type_reg <= TypeSpaces;
                    end else if ({2'b00, tab_reg} > space4) begin
                        type_reg <= TypeTabs;
                    end else begin
                        type_reg <= TypeNone;
                    end
                end
                StSum: begin
                    if (!rd_pend_reg) begin
                        // First read of a divisor is issued this cycle.
                        rd_pend_reg <= 1'b1;
                        if (tab_reg == '0 && space_reg == '0) begin
                            type_reg <= TypeNone;
                        end else if ({2'b00, space_reg} > tab4) begin
                            type_reg <= TypeSpaces;
                        end else if ({2'b00, tab_reg} > space4) begin
                            type_reg <= TypeTabs;
                        end else begin
                            type_reg <= TypeNone;
                        end
                    end else begin
                        wsum_reg <= wsum_reg + 22'(ram_rdata);
                        if (i_nx < (HistIdxW+1)'(HistDepth)) begin
                            i_reg <= i_nx[HistIdxW-1:0];
                        end else begin
                            rd_pend_reg <= 1'b0;
                        end
                    end
                end
                StPick: begin
                    if ({1'b0, wsum_reg} > {1'b0, best32[22:1]} + {22'd0, best32[0]} - 23'd0
                        && {1'b0, wsum_reg} > ({1'b0, best_reg} + {2'b00, best_reg[21:1]})) begin
                        best_reg <= wsum_reg;
                        win_reg  <= k_reg;
                    end
                    wsum_reg <= '0;
                    k_reg    <= k_reg - 1'b1;
                    i_reg    <= k_reg - 1'b1;
                end
                StOut: begin
                    if (m_ready) begin
                        addr_reg <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid       = state_reg == StOut;
    assign m_indent_type = type_reg;
    assign m_indent_size = (type_reg == TypeSpaces) ? 6'(win_reg) : 6'd0;

    `ISD_ASSERT_IMPL(a_out_only_done, aclk, aresetn, m_valid, state_reg == StOut)
    `ISD_ASSERT_IMPL(a_pop_only_run, aclk, aresetn, q_pop, state_reg == StRun)
    `ISD_ASSERT_NEXT(a_out_to_clear, aclk, aresetn, m_valid && m_ready, state_reg == StClear)
endmodule

// ===== rtl/core/indent_style_detector.sv =====
// Top level of the indent style detector.
// Usage: one input word per text line on the s_ channel (s_valid/s_ready)
// carrying its indent width, first byte, first byte after the blanks and a
// last-line flag. Configuration words (cfg_valid/cfg_ready, cfg_index,
// cfg_data) set star-continuation skipping (index 0) and the line limit
// (index 1); they are taken at any time but are meant to be written idle.
// The front end classifies each line in the cycle it is accepted and pushes
// it into a two-entry queue; the back end tallies it. A space line also
// passes through StRmw (histogram read-modify-write through the histogram
// RAM), during which the next line waits in the queue. On the last line the
// back end walks the divisor sums: for each of the 52 divisors it reads and
// adds the histogram entries at its multiples and compares the sum in StPick,
// then presents one result word on m_ (m_valid/m_ready). A stalled receiver
// holds the result and the back end; the front keeps taking lines until the
// queue fills. After reset and after each result the back end clears all 54
// histogram RAM entries, one entry per cycle, during which lines queue up but
// are not tallied yet.
module indent_style_detector
    import isd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_indent_width,
    input  logic [7:0]  s_head_char,
    input  logic [7:0]  s_after_indent_char,
    input  logic        s_last_line,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_indent_type,
    output logic [5:0]  m_indent_size
);
    logic     q_push, q_full, q_pop, q_ne;
    isd_cmd_t q_in, q_head;

    isd_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_indent_width, .s_head_char,
        .s_after_indent_char, .s_last_line, .cfg_valid, .cfg_ready,
        .cfg_index, .cfg_data, .q_push, .q_cmd(q_in), .q_full
    );

    isd_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_cmd(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    isd_back u_back (
        .aclk, .aresetn, .q_valid(q_ne), .q_cmd(q_head), .q_pop,
        .m_valid, .m_ready, .m_indent_type, .m_indent_size
    );
endmodule
